// ===== design/smm_pkg.sv =====
`default_nettype none

package smm_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int RESULT_CAP  = 16;

  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_PROD = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_UNLOAD
  } state_t;

  // one term of the dot product, travelling along the chain
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [3:0]         k;
    logic signed [15:0] a;
  } tok_t;

  typedef struct packed {
    logic               en;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] data;
  } bwr_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic               sat;
  } res_t;

endpackage

`default_nettype wire

// ===== design/smm_cell.sv =====
`default_nettype none

module smm_cell #(
  parameter int NCELL = smm_pkg::RESULT_CAP,
  parameter int COL   = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smm_pkg::bwr_t     wr,
  input  wire smm_pkg::tok_t     tok_in,
  output      smm_pkg::tok_t     tok_out,
  input  wire smm_pkg::cell_ctl_t ctl,
  input  wire smm_pkg::res_t     res_in,
  output      smm_pkg::res_t     res_out,
  output      logic              done
);

  localparam int IDX_W = $clog2(NCELL);

  // column COL of the right matrix
  logic signed [15:0] bmem [NCELL];

  logic               v1_r, first1_r, last1_r;
  logic [3:0]         k1_r;
  logic signed [15:0] a1_r, b1_r;
  logic               v2_r, first2_r, last2_r;
  logic signed [31:0] prod_r;
  logic signed [47:0] acc_r, acc_nxt;
  logic               sat_r, sat_nxt;
  logic               done_r;
  smm_pkg::res_t      res_r;

  logic signed [47:0] acc_base;
  logic signed [48:0] sum;
  logic               clip_hi, clip_lo;

  always_comb begin
    acc_base = first2_r ? 48'sd0 : acc_r;
    sum      = 49'(acc_base) + 49'(prod_r);
    clip_hi  = sum > 49'(smm_pkg::ACC_MAX);
    clip_lo  = sum < 49'(smm_pkg::ACC_MIN);
    if (clip_hi) begin
      acc_nxt = smm_pkg::ACC_MAX;
    end else if (clip_lo) begin
      acc_nxt = smm_pkg::ACC_MIN;
    end else begin
      acc_nxt = sum[47:0];
    end
    sat_nxt = (first2_r ? 1'b0 : sat_r) | clip_hi | clip_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= tok_in.valid;
      v2_r   <= v1_r;
      done_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.col == 4'(COL)) begin
      bmem[wr.row[IDX_W-1:0]] <= wr.data;
    end
    b1_r     <= bmem[tok_in.k[IDX_W-1:0]];
    a1_r     <= tok_in.a;
    k1_r     <= tok_in.k;
    first1_r <= tok_in.first;
    last1_r  <= tok_in.last;
    prod_r   <= a1_r * b1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    if (v2_r) begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
    if (ctl.load) begin
      res_r.value <= acc_r;
      res_r.sat   <= sat_r;
    end else if (ctl.shift) begin
      res_r <= res_in;
    end
  end

  always_comb begin
    tok_out.valid = v1_r;
    tok_out.first = first1_r;
    tok_out.last  = last1_r;
    tok_out.k     = k1_r;
    tok_out.a     = a1_r;
  end

  assign res_out = res_r;
  assign done    = done_r;

endmodule

`default_nettype wire

// ===== design/smm_ctrl.sv =====
`default_nettype none

module smm_ctrl #(
  parameter int NCELL = smm_pkg::RESULT_CAP
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [smm_pkg::SIZE_W-1:0] active_size,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [3:0]                 in_row_index,
  input  wire logic [3:0]                 in_col_index,
  input  wire logic signed [15:0]         in_element_value,
  output      smm_pkg::tok_t              tok_out,
  output      smm_pkg::bwr_t              bwr,
  output      smm_pkg::cell_ctl_t         ctl,
  input  wire logic [NCELL-1:0]           done_v,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [3:0]                 out_col,
  output      logic                       out_last
);

  localparam int IDX_W = $clog2(NCELL);
  localparam int SW    = smm_pkg::SIZE_W;

  // left matrix, rows and columns below NCELL
  logic signed [15:0] amem [NCELL][NCELL];

  smm_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic               tok_v_r;
  logic               tok_first_r, tok_last_r;
  logic [IDX_W-1:0]   tok_k_r;
  logic signed [15:0] a_rd_r;

  logic [SW-1:0]      n_eff, n_m1;
  logic               in_range, row_ok, k_last, col_last, wr_a;
  smm_pkg::op_t       op;

  always_comb begin
    if (active_size == '0) begin
      n_eff = SW'(1);
    end else if (active_size > SW'(NCELL)) begin
      n_eff = SW'(NCELL);
    end else begin
      n_eff = active_size;
    end
    n_m1     = n_eff - SW'(1);
    in_range = ({1'b0, in_row_index} < SW'(NCELL)) && ({1'b0, in_col_index} < SW'(NCELL));
    row_ok   = {1'b0, in_row_index} < n_eff;
    k_last   = SW'(k_r) == n_m1;
    col_last = SW'(col_r) == n_m1;
    op       = smm_pkg::op_t'(in_operation);
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    k_nxt     = k_r;
    col_nxt   = col_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl       = '0;
    wr_a      = 1'b0;
    bwr.en    = 1'b0;
    bwr.row   = in_row_index;
    bwr.col   = in_col_index;
    bwr.data  = in_element_value;
    unique case (state_r)
      smm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (op)
            smm_pkg::OP_WR_A: wr_a   = in_range;
            smm_pkg::OP_WR_B: bwr.en = in_range;
            smm_pkg::OP_PROD: begin
              if (row_ok) begin
                row_nxt   = in_row_index[IDX_W-1:0];
                k_nxt     = '0;
                state_nxt = smm_pkg::ST_FEED;
              end
            end
            default: ;
          endcase
        end
      end
      smm_pkg::ST_FEED: begin
        if (k_last) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end else begin
          k_nxt = IDX_W'(k_r + 1'b1);
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (done_v[n_m1[IDX_W-1:0]]) begin
          ctl.load  = 1'b1;
          col_nxt   = '0;
          state_nxt = smm_pkg::ST_UNLOAD;
        end
      end
      smm_pkg::ST_UNLOAD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          ctl.shift = 1'b1;
          if (col_last) begin
            state_nxt = smm_pkg::ST_IDLE;
          end else begin
            col_nxt = IDX_W'(col_r + 1'b1);
          end
        end
      end
      default: state_nxt = smm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_IDLE;
      row_r   <= '0;
      k_r     <= '0;
      col_r   <= '0;
      tok_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      k_r     <= k_nxt;
      col_r   <= col_nxt;
      tok_v_r <= state_r == smm_pkg::ST_FEED;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      amem[in_row_index[IDX_W-1:0]][in_col_index[IDX_W-1:0]] <= in_element_value;
    end
    a_rd_r      <= amem[row_r][k_r];
    tok_first_r <= k_r == '0;
    tok_last_r  <= k_last;
    tok_k_r     <= k_r;
  end

  always_comb begin
    tok_out.valid = tok_v_r;
    tok_out.first = tok_first_r;
    tok_out.last  = tok_last_r;
    tok_out.k     = 4'(tok_k_r);
    tok_out.a     = a_rd_r;
  end

  assign out_col  = 4'(col_r);
  assign out_last = col_last;

endmodule

`default_nettype wire

// ===== design/square_matrix_multiply.sv =====
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------------
// in       | in_valid / in_stall  | in_operation, in_row_index, in_col_index,
//          |                      | in_element_value
// out      | out_valid / out_stall| out_product_value, out_product_col, out_saturated,
//          |                      | out_last_of_row
// cfg      | cfg_wr_en            | cfg_wr_data (active_size)
//
// element writes are taken back to back while no product request is running
// a product request with size n feeds n terms from the left store read port through the
// cell chain, waits for the last active cell, then emits n result items, one per column
// no item is taken while a row is being computed or emitted
// synchronous active-low reset clears control only; both stores stay undefined
// a stall on out holds the current item and the whole unload

`default_nettype none

module square_matrix_multiply #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [smm_pkg::SIZE_W-1:0] cfg_wr_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [1:0]                 in_operation,
  input  wire logic [3:0]                 in_row_index,
  input  wire logic [3:0]                 in_col_index,
  input  wire logic signed [15:0]         in_element_value,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic signed [47:0]         out_product_value,
  output      logic [3:0]                 out_product_col,
  output      logic                       out_saturated,
  output      logic                       out_last_of_row
);

  localparam int NCELL = (MAX_DIM < smm_pkg::RESULT_CAP) ? MAX_DIM : smm_pkg::RESULT_CAP;

  logic [smm_pkg::SIZE_W-1:0] active_size_r;

  smm_pkg::tok_t      tok_c [NCELL+1];
  smm_pkg::res_t      res_c [NCELL+1];
  smm_pkg::bwr_t      bwr;
  smm_pkg::cell_ctl_t ctl;
  logic [NCELL-1:0]   done_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= smm_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      active_size_r <= cfg_wr_data;
    end
  end

  smm_ctrl #(
    .NCELL(NCELL)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .active_size     (active_size_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_element_value(in_element_value),
    .tok_out         (tok_c[0]),
    .bwr             (bwr),
    .ctl             (ctl),
    .done_v          (done_v),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_col         (out_product_col),
    .out_last        (out_last_of_row)
  );

  assign res_c[NCELL] = '0;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    smm_cell #(
      .NCELL(NCELL),
      .COL  (j)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (bwr),
      .tok_in (tok_c[j]),
      .tok_out(tok_c[j+1]),
      .ctl    (ctl),
      .res_in (res_c[j+1]),
      .res_out(res_c[j]),
      .done   (done_v[j])
    );
  end

  assign out_product_value = res_c[0].value;
  assign out_saturated     = res_c[0].sat;

endmodule

`default_nettype wire

// ===== design/smm_checker.sv =====
`default_nettype none

module smm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [47:0] out_product_value,
  input wire logic [3:0]         out_product_col,
  input wire logic               out_saturated,
  input wire logic               out_last_of_row
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_product_value)
      && $stable(out_product_col) && $stable(out_saturated) && $stable(out_last_of_row))
    else $error("stalled result item changed");

  // no item taken while a row is emitted
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during row output");

  // a row comes out without gaps
  a_row_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_row |=> out_valid)
    else $error("gap inside a product row");

  // columns count up by one
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_row |=>
      out_product_col == 4'($past(out_product_col) + 4'd1))
    else $error("product column did not advance by one");

  // nothing follows the last item of a row at once
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_of_row |=> !out_valid)
    else $error("result after last item of row");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_product_value(out_product_value),
  .out_product_col  (out_product_col),
  .out_saturated    (out_saturated),
  .out_last_of_row  (out_last_of_row)
);

`default_nettype wire
